// File: design/afr_pkg.sv
// Shared constants and inter-module types for the addressed frame receiver.
`default_nettype none
package afr_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int LEN_W       = 6;
	localparam int TDATA_W     = 40;

	// payload buffer write from the parser
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_req_t;

	// frame accepted on its checksum byte
	typedef struct packed {
		logic             start;
		logic [7:0]       src;
		logic [7:0]       id;
		logic [LEN_W-1:0] len;
	} frame_t;

endpackage
`default_nettype wire

// File: design/addressed_frame_receiver.sv
// Top level of the addressed frame receiver: address register, parser and payload buffer.
//
//  channel   dir  width  contents
//  s_*       in   8      rx_byte in s_tdata
//  m_*       out  40     tdata: source_addr, frame_id, payload_len, payload_byte, byte_index;
//                        tuser: empty_frame; tlast: last
//  cfg_*     in   8      own_address write
//
// One received byte is taken per cycle while no frame is being read out.
// A good frame blocks s_tready after its checksum byte until one payload memory read per
// payload byte (one read if empty) has issued; reads issue and results leave at one per
// cycle while m_* is not stalled. The first result passes the readout sequencer, read stage
// and output register. Backpressure on m_* holds the read stage and the readout.
// Reset clears the parser, readout and own_address; the payload memory is not cleared.
`default_nettype none
module addressed_frame_receiver (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [7:0]              cfg_wdata,  // own_address
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [7:0]              s_tdata,    // rx_byte
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// [7:0] source_addr, [15:8] frame_id, [21:16] payload_len,
	// [29:22] payload_byte, [34:30] byte_index, [39:35] zero
	output logic [afr_pkg::TDATA_W-1:0]  m_tdata,
	output logic                         m_tuser,    // empty_frame
	output logic                         m_tlast     // last
);
	import afr_pkg::*;

	logic [7:0] own_addr_q;
	logic       busy;
	logic       rx_fire;
	wr_req_t    wr;
	frame_t     frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) own_addr_q <= 8'd0;
		else if (cfg_we) own_addr_q <= cfg_wdata;
	end

	assign s_tready = !busy;
	assign rx_fire  = s_tvalid && s_tready;

	afr_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.own_address (own_addr_q),
		.rx_fire     (rx_fire),
		.rx_byte     (s_tdata),
		.wr          (wr),
		.frame       (frame)
	);

	afr_buffer u_buffer (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.frame    (frame),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// File: design/afr_parser.sv
// Header and payload parser: address match, field capture, sum and buffer writes.
`default_nettype none
module afr_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [7:0]      own_address,
	input  wire logic            rx_fire,
	input  wire logic [7:0]      rx_byte,
	output afr_pkg::wr_req_t     wr,
	output afr_pkg::frame_t      frame
);
	import afr_pkg::*;

	typedef enum logic [2:0] {
		PH_DEST,
		PH_SRC,
		PH_ID,
		PH_LEN,
		PH_DATA,
		PH_CHECK
	} phase_t;

	phase_t     phase_q;
	logic [7:0] src_q;
	logic [7:0] id_q;
	logic [7:0] len_q;
	logic [7:0] fill_q;
	logic [7:0] sum_q;
	logic [7:0] fill_nxt;
	logic       sum_ok;

	assign fill_nxt = fill_q + 8'd1;
	assign sum_ok   = (rx_byte == sum_q) && (len_q <= 8'(MAX_PAYLOAD));

	always_comb begin
		wr.en       = rx_fire && (phase_q == PH_DATA) && (fill_q < 8'(MAX_PAYLOAD));
		wr.addr     = fill_q[ADDR_W-1:0];
		wr.data     = rx_byte;
		frame.start = rx_fire && (phase_q == PH_CHECK) && sum_ok;
		frame.src   = src_q;
		frame.id    = id_q;
		frame.len   = len_q[LEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DEST;
			src_q   <= 8'd0;
			id_q    <= 8'd0;
			len_q   <= 8'd0;
			fill_q  <= 8'd0;
			sum_q   <= 8'd0;
		end else if (rx_fire) begin
			unique case (phase_q)
				PH_DEST: begin
					if (rx_byte == own_address) phase_q <= PH_SRC;
				end
				PH_SRC: begin
					src_q   <= rx_byte;
					id_q    <= 8'd0;
					phase_q <= PH_ID;
				end
				PH_ID: begin
					id_q    <= rx_byte;
					phase_q <= PH_LEN;
				end
				PH_LEN: begin
					len_q   <= rx_byte;
					fill_q  <= 8'd0;
					sum_q   <= 8'd0;
					// empty frame goes straight to its checksum
					phase_q <= (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
				end
				PH_DATA: begin
					sum_q  <= sum_q + rx_byte;
					fill_q <= fill_nxt;
					if (fill_nxt >= len_q) phase_q <= PH_CHECK;
				end
				PH_CHECK: begin
					phase_q <= PH_DEST;
				end
				default: phase_q <= PH_DEST;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (phase_q == PH_DATA) && (fill_q < len_q))
		else $error("payload write outside the payload field");
	assert property (@(posedge clk) disable iff (!arst_n)
		frame.start |=> (phase_q == PH_DEST))
		else $error("parser did not return to address hunt after a frame");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (len_q != 8'd0))
		else $error("payload field entered with zero length");

endmodule
`default_nettype wire

// File: design/afr_buffer.sv
// Payload memory and readout sequencer with read stage and output register.
`default_nettype none
module afr_buffer (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire afr_pkg::wr_req_t             wr,
	input  wire afr_pkg::frame_t              frame,
	output logic                              busy,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [afr_pkg::TDATA_W-1:0]       m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast
);
	import afr_pkg::*;

	logic [7:0]        mem [MAX_PAYLOAD];

	logic              emit_q;
	logic [7:0]        src_q;
	logic [7:0]        id_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] rd_idx_q;

	logic              s1_v_s1;
	logic [7:0]        src_s1;
	logic [7:0]        id_s1;
	logic [LEN_W-1:0]  len_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic              empty_s1;
	logic              last_s1;
	logic [7:0]        rd_data_s1;

	logic              out_v_q;
	logic [7:0]        out_src_q;
	logic [7:0]        out_id_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [7:0]        out_byte_q;
	logic [ADDR_W-1:0] out_idx_q;
	logic              out_empty_q;
	logic              out_last_q;

	logic              empty;
	logic              last_issue;
	logic              s1_move;
	logic              issue;

	assign empty      = (len_q == '0);
	assign last_issue = empty || ((LEN_W'(rd_idx_q) + LEN_W'(1)) == len_q);
	assign s1_move    = s1_v_s1 && (!out_v_q || m_tready);
	assign issue      = emit_q && (!s1_v_s1 || s1_move);
	assign busy       = emit_q;

	// memory: one write port from the parser, one registered read port
	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr] <= wr.data;
		if (issue) rd_data_s1 <= mem[rd_idx_q];
	end

	// readout sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q   <= 1'b0;
			rd_idx_q <= '0;
		end else if (frame.start) begin
			emit_q   <= 1'b1;
			rd_idx_q <= '0;
		end else if (issue) begin
			if (last_issue) emit_q <= 1'b0;
			rd_idx_q <= rd_idx_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (frame.start) begin
			src_q <= frame.src;
			id_q  <= frame.id;
			len_q <= frame.len;
		end
	end

	// read stage: holds while the output register is full and stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s1_v_s1 <= 1'b0;
		else if (issue) s1_v_s1 <= 1'b1;
		else if (s1_move) s1_v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			src_s1   <= src_q;
			id_s1    <= id_q;
			len_s1   <= len_q;
			idx_s1   <= rd_idx_q;
			empty_s1 <= empty;
			last_s1  <= last_issue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (s1_move) out_v_q <= 1'b1;
		else if (m_tready) out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_src_q   <= src_s1;
			out_id_q    <= id_s1;
			out_len_q   <= len_s1;
			out_byte_q  <= empty_s1 ? 8'd0 : rd_data_s1;
			out_idx_q   <= idx_s1;
			out_empty_q <= empty_s1;
			out_last_q  <= last_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, out_idx_q, out_byte_q, out_len_q, out_id_q, out_src_q};
	assign m_tuser  = out_empty_q;
	assign m_tlast  = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		frame.start |-> !emit_q)
		else $error("new frame started during readout");
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_s1 && !s1_move) |-> !issue)
		else $error("read issued into a stalled read stage");
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit_q && !empty) |-> (LEN_W'(rd_idx_q) < len_q))
		else $error("read index ran past the frame length");
	assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !emit_q)
		else $error("buffer written during readout");

endmodule
`default_nettype wire
